// ===== design/whitespace_comment_stripper_assert.svh =====
// Assertion macros shared by the stripper modules.
`ifndef WHITESPACE_COMMENT_STRIPPER_ASSERT_SVH
`define WHITESPACE_COMMENT_STRIPPER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, off while reset is asserted
`define WCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define WCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define WCS_ASSERT(label, prop, msg)
`define WCS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/wcs_pkg.sv =====
package wcs_pkg;

  localparam int unsigned CP_BITS  = 21;
  localparam int unsigned OUT_POS_BITS = 32;
  localparam int unsigned MAX_RESULTS = 3;

  localparam logic [CP_BITS-1:0] CP_SLASH = 21'd47;
  localparam logic [CP_BITS-1:0] CP_STAR  = 21'd42;
  localparam logic [CP_BITS-1:0] CP_NONE  = 21'd0;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // One input beat
  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic               final_item;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    logic                    kind;
    logic [CP_BITS-1:0]      char_out;
    logic [OUT_POS_BITS-1:0] position;
    logic                    run_last;
  } out_beat_t;

  // Results produced by one accepted input, packed from slot 0
  typedef struct packed {
    logic [1:0]                       cnt;
    out_beat_t [MAX_RESULTS-1:0]      beat;
  } push_grp_t;

endpackage

// ===== design/wcs_scan.sv =====
module wcs_scan #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               acc,
  input  wcs_pkg::in_beat_t  in_data,
  output wcs_pkg::push_grp_t push
);

`include "whitespace_comment_stripper_assert.svh"

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_HELD   = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4
  } mode_t;

  localparam int unsigned NCAND = 4;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] held_r, held_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] pos_inc;

  wcs_pkg::out_beat_t [NCAND-1:0] cand;
  logic [NCAND-1:0]               cval;
  logic [1:0]                     k;
  logic                           is_slash, is_star, is_space, is_lt;
  logic [wcs_pkg::CP_BITS-1:0]    c;

  function automatic wcs_pkg::out_beat_t mk_beat(logic kind, logic [wcs_pkg::CP_BITS-1:0] ch,
                                                 logic [POSITION_BITS-1:0] pos);
    wcs_pkg::out_beat_t b;
    b.kind     = kind;
    b.char_out = ch;
    b.position = wcs_pkg::OUT_POS_BITS'(pos);
    b.run_last = 1'b0;
    return b;
  endfunction

  // Character classes
  assign c        = in_data.code_point;
  assign is_slash = (c == wcs_pkg::CP_SLASH);
  assign is_star  = (c == wcs_pkg::CP_STAR);
  assign is_lt    = (c == 21'd10) || (c == 21'd13) || (c == 21'd8232) || (c == 21'd8233);
  assign is_space = ((c > 21'd8) && (c < 21'd14)) || ((c > 21'd8192) && (c < 21'd8202)) ||
                    (c == 21'd32) || (c == 21'd160) || (c == 21'd8232) || (c == 21'd8233) ||
                    (c == 21'd5760) || (c == 21'd6158) || (c == 21'd8239) ||
                    (c == 21'd8287) || (c == 21'd12288) || (c == 21'd65279);

  assign pos_inc = pos_r + POSITION_BITS'(1);

  // Mode update and result candidates
  always_comb begin
    mode_nxt = mode_r;
    held_nxt = held_r;
    cval     = '0;
    cand[0]  = mk_beat(wcs_pkg::KIND_CHAR, wcs_pkg::CP_SLASH, held_r);
    cand[1]  = mk_beat(wcs_pkg::KIND_CHAR, c, pos_r);
    unique case (mode_r)
      MODE_HELD: begin
        if (is_slash) begin
          mode_nxt = MODE_LINE;
        end else if (is_star) begin
          mode_nxt = MODE_BLOCK;
        end else begin
          cval[0]  = 1'b1;
          mode_nxt = MODE_NORMAL;
          cval[1]  = !is_space;
        end
      end
      MODE_LINE: begin
        if (is_lt) mode_nxt = MODE_NORMAL;
      end
      MODE_BLOCK: begin
        if (is_star) mode_nxt = MODE_BSTAR;
      end
      MODE_BSTAR: begin
        if (is_slash) mode_nxt = MODE_NORMAL;
        else if (!is_star) mode_nxt = MODE_BLOCK;
      end
      default: begin
        // a slash here is held for one beat of lookahead
        if (is_slash) begin
          mode_nxt = MODE_HELD;
          held_nxt = pos_r;
        end else begin
          mode_nxt = MODE_NORMAL;
          cval[1]  = !is_space;
        end
      end
    endcase
    // end of input: flush a held slash, then the end marker
    cand[2] = mk_beat(wcs_pkg::KIND_CHAR, wcs_pkg::CP_SLASH, held_nxt);
    cand[3] = mk_beat(wcs_pkg::KIND_END, wcs_pkg::CP_NONE, pos_inc);
    if (in_data.final_item) begin
      cval[2]  = (mode_nxt == MODE_HELD);
      cval[3]  = 1'b1;
      mode_nxt = MODE_NORMAL;
      held_nxt = '0;
      pos_nxt  = '0;
    end else begin
      pos_nxt  = pos_inc;
    end
  end

  // Pack valid candidates into result slots, tag the last one
  always_comb begin
    push.beat = '0;
    k         = 2'd0;
    for (int i = 0; i < NCAND; i++) begin
      if (cval[i] && (k != 2'd3)) begin
        push.beat[k] = cand[i];
        k            = k + 2'd1;
      end
    end
    if (k != 2'd0) push.beat[k - 2'd1].run_last = 1'b1;
    push.cnt = acc ? k : 2'd0;
  end

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      held_r <= '0;
      pos_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
      pos_r  <= pos_nxt;
    end
  end

  `WCS_ASSERT(a_final_restarts, acc && in_data.final_item |=> mode_r == MODE_NORMAL && pos_r == '0, "final beat did not restart the scanner")
  `WCS_ASSERT(a_final_emits, acc && in_data.final_item |-> push.cnt != 2'd0, "final beat produced no end marker")

endmodule

// ===== design/wcs_queue.sv =====
module wcs_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  wcs_pkg::push_grp_t  push,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output wcs_pkg::out_beat_t  out_data
);

`include "whitespace_comment_stripper_assert.svh"

  localparam int unsigned DEPTH  = 4;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  wcs_pkg::out_beat_t mem_r [DEPTH];
  logic [PTR_W-1:0]   rd_r, wr_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;
  // room for a full burst of results is required before a new beat is taken
  assign full      = (cnt_r > CNT_W'(DEPTH - wcs_pkg::MAX_RESULTS));
  assign cnt_nxt   = cnt_r + CNT_W'(push.cnt) - CNT_W'(pop);

  // Result storage
  always_ff @(posedge clk) begin
    for (int i = 0; i < wcs_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < push.cnt) mem_r[wr_r + PTR_W'(i)] <= push.beat[i];
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= '0;
      wr_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + PTR_W'(push.cnt);
      if (pop) rd_r <= rd_r + PTR_W'(1);
      cnt_r <= cnt_nxt;
    end
  end

  `WCS_ASSERT(a_no_overflow, cnt_r <= CNT_W'(DEPTH), "result queue overflow")
  `WCS_ASSERT(a_push_when_room, push.cnt != 2'd0 |-> !full, "results pushed while queue full")
  `WCS_ASSERT(a_empty_push_shows, push.cnt != 2'd0 && cnt_r == '0 |=> out_valid, "push not shown")

endmodule

// ===== design/whitespace_comment_stripper.sv =====
// Whitespace and comment stripper: takes one code point per beat and passes on only token
// material, each with its index in the input. Whitespace, line comments and block comments
// are dropped; a slash is held one beat until the next code point shows whether it opens a
// comment, and the final input flushes a held slash and adds an end marker, then the position
// restarts at zero. Results are written into the result queue and leave it in order. An
// input beat is accepted every cycle while the 4-entry result queue holds at most one result,
// and the result port drains one beat per cycle unless the receiver stalls, so a stream flows
// without input stalls while each input yields at most one result. An input that yields two
// or three results stalls the input side until the queue drains; receiver stalls add to that.
module whitespace_comment_stripper #(
  parameter int unsigned POSITION_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  wcs_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wcs_pkg::out_beat_t out_data
);

  wcs_pkg::push_grp_t push;
  logic               full;
  logic               acc;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  // Mode tracking and result generation
  wcs_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .push    (push)
  );

  // Result queue, one beat out per cycle unless the receiver stalls
  wcs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== test/stripper_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels of the stripper, predicts the result beats of every
// accepted code point and compares them in order with the beats that leave.
module stripper_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  wcs_pkg::in_beat_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  wcs_pkg::out_beat_t out_data,
  output int                 mismatches,
  output int                 pending,
  output int                 results_seen
);

  typedef enum logic [2:0] {
    SCAN, HELD_SLASH, LINE_CMT, BLOCK_CMT, BLOCK_STAR
  } scan_mode_t;

  // Predictor state
  scan_mode_t  scan_mode;
  logic [31:0] slash_pos;
  logic [31:0] next_pos;

  wcs_pkg::out_beat_t expected_beats[$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
  end

  function automatic bit is_line_break(logic [wcs_pkg::CP_BITS-1:0] cp);
    return cp == 21'd10 || cp == 21'd13 || cp == 21'd8232 || cp == 21'd8233;
  endfunction

  function automatic bit is_blank(logic [wcs_pkg::CP_BITS-1:0] cp);
    if (cp >= 21'd9 && cp <= 21'd13) return 1'b1;
    if (cp >= 21'd8193 && cp <= 21'd8201) return 1'b1;
    return cp == 21'd32   || cp == 21'd160  || cp == 21'd5760  || cp == 21'd6158 ||
           cp == 21'd8232 || cp == 21'd8233 || cp == 21'd8239  || cp == 21'd8287 ||
           cp == 21'd12288 || cp == 21'd65279;
  endfunction

  function automatic wcs_pkg::out_beat_t make_beat(logic k, logic [wcs_pkg::CP_BITS-1:0] cp,
                                                   logic [31:0] pos);
    wcs_pkg::out_beat_t b;
    b.kind     = k;
    b.char_out = cp;
    b.position = pos;
    b.run_last = 1'b0;
    return b;
  endfunction

  // Advance the predictor by one code point and queue the beats it causes
  function automatic void predict_stripped_beats(wcs_pkg::in_beat_t b);
    wcs_pkg::out_beat_t grp[$];
    logic [31:0]        pos;
    bit                 plain;
    pos      = next_pos;
    next_pos = next_pos + 32'd1;
    plain    = 1'b0;
    unique case (scan_mode)
      HELD_SLASH: begin
        if (b.code_point == wcs_pkg::CP_SLASH) begin
          scan_mode = LINE_CMT;
        end else if (b.code_point == wcs_pkg::CP_STAR) begin
          scan_mode = BLOCK_CMT;
        end else begin
          // not a comment after all: the slash goes out first
          grp = {grp, make_beat(wcs_pkg::KIND_CHAR, wcs_pkg::CP_SLASH, slash_pos)};
          scan_mode = SCAN;
          plain     = 1'b1;
        end
      end
      LINE_CMT: begin
        if (is_line_break(b.code_point)) scan_mode = SCAN;
      end
      BLOCK_CMT: begin
        if (b.code_point == wcs_pkg::CP_STAR) scan_mode = BLOCK_STAR;
      end
      BLOCK_STAR: begin
        if (b.code_point == wcs_pkg::CP_SLASH) scan_mode = SCAN;
        else if (b.code_point != wcs_pkg::CP_STAR) scan_mode = BLOCK_CMT;
      end
      default: plain = 1'b1;
    endcase

    if (plain) begin
      if (b.code_point == wcs_pkg::CP_SLASH) begin
        scan_mode = HELD_SLASH;
        slash_pos = pos;
      end else if (!is_blank(b.code_point)) begin
        grp = {grp, make_beat(wcs_pkg::KIND_CHAR, b.code_point, pos)};
      end
    end

    // end of text: flush a held slash, add the end marker, start over
    if (b.final_item) begin
      if (scan_mode == HELD_SLASH)
        grp = {grp, make_beat(wcs_pkg::KIND_CHAR, wcs_pkg::CP_SLASH, slash_pos)};
      grp = {grp, make_beat(wcs_pkg::KIND_END, wcs_pkg::CP_NONE, next_pos)};
      scan_mode = SCAN;
      slash_pos = '0;
      next_pos  = '0;
    end

    if (grp.size() > 0) grp[grp.size()-1].run_last = 1'b1;
    expected_beats = {expected_beats, grp};
  endfunction

  always @(posedge clk) begin
    wcs_pkg::out_beat_t want;
    if (!rst_n) begin
      scan_mode = SCAN;
      slash_pos = '0;
      next_pos  = '0;
      expected_beats.delete();
    end else begin
      // result side first: nothing leaving now was caused by this edge's input
      if (out_valid && !out_stall) begin
        results_seen = results_seen + 1;
        if (expected_beats.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result beat kind=%0b char=%0d pos=%0d last=%0b",
                     $realtime, out_data.kind, out_data.char_out, out_data.position,
                     out_data.run_last);
          mismatches = mismatches + 1;
        end else begin
          want = expected_beats.pop_front();
          if (want.kind !== out_data.kind || want.char_out !== out_data.char_out ||
              want.position !== out_data.position || want.run_last !== out_data.run_last) begin
            if (mismatches < 10) begin
              $display("%0t: result mismatch exp kind=%0b char=%0d pos=%0d last=%0b",
                       $realtime, want.kind, want.char_out, want.position, want.run_last);
              $display("%0t:                 got kind=%0b char=%0d pos=%0d last=%0b",
                       $realtime, out_data.kind, out_data.char_out, out_data.position,
                       out_data.run_last);
            end
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_stripped_beats(in_data);
    end
    pending = expected_beats.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int HOLD_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  wcs_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  wcs_pkg::out_beat_t out_data;

  int mismatches;
  int pending;
  int results_seen;
  int items_sent = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  whitespace_comment_stripper u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stripper_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: random stalls, or one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one beat; entered and left at a falling edge
  task automatic send_cp(logic [wcs_pkg::CP_BITS-1:0] cp, bit fin);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_data.code_point <= cp;
    in_data.final_item <= fin;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent = items_sent + 1;
    @(negedge clk);
  endtask

  // Stop offering until every predicted beat has left
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  // Whitespace members and their neighbors
  function automatic logic [wcs_pkg::CP_BITS-1:0] pick_blank();
    unique case ($urandom_range(0, 19))
      0: return 21'd8;      1: return 21'd9;      2: return 21'd11;     3: return 21'd12;
      4: return 21'd14;     5: return 21'd32;     6: return 21'd160;    7: return 21'd5760;
      8: return 21'd6158;   9: return 21'd8192;   10: return 21'd8193;  11: return 21'd8201;
      12: return 21'd8202;  13: return 21'd8239;  14: return 21'd8287;  15: return 21'd12288;
      16: return 21'd65279; 17: return 21'd31;    18: return 21'd33;
      default: return wcs_pkg::CP_BITS'($urandom_range(8193, 8201));
    endcase
  endfunction

  function automatic logic [wcs_pkg::CP_BITS-1:0] pick_line_break();
    unique case ($urandom_range(0, 3))
      0: return 21'd10;
      1: return 21'd13;
      2: return 21'd8232;
      default: return 21'd8233;
    endcase
  endfunction

  function automatic logic [wcs_pkg::CP_BITS-1:0] pick_cp();
    unique case ($urandom_range(0, 9))
      0, 1, 2: return wcs_pkg::CP_BITS'($urandom_range(33, 126));
      3: return wcs_pkg::CP_SLASH;
      4: return wcs_pkg::CP_STAR;
      5: return pick_blank();
      6: return pick_line_break();
      7: return wcs_pkg::CP_BITS'($urandom_range(0, 32'h1FFFFF));
      8: return wcs_pkg::CP_BITS'($urandom_range(127, 70000));
      default: return 21'd32;
    endcase
  endfunction

  function automatic bit pick_final();
    return $urandom_range(99) < 4;
  endfunction

  // One random run: a line comment, a block comment or a lone code point
  task automatic send_random_run();
    int sel;
    int body;
    sel = $urandom_range(99);
    if (sel < 20) begin
      send_cp(wcs_pkg::CP_SLASH, 1'b0);
      send_cp(wcs_pkg::CP_SLASH, pick_final());
      body = $urandom_range(1, 4);
      repeat (body) send_cp(pick_cp(), pick_final());
      send_cp(pick_line_break(), pick_final());
    end else if (sel < 40) begin
      send_cp(wcs_pkg::CP_SLASH, 1'b0);
      send_cp(wcs_pkg::CP_STAR, pick_final());
      body = $urandom_range(0, 4);
      repeat (body) send_cp(pick_cp(), pick_final());
      send_cp(wcs_pkg::CP_STAR, pick_final());
      send_cp(wcs_pkg::CP_SLASH, pick_final());
    end else begin
      send_cp(pick_cp(), pick_final());
    end
  endtask

  task automatic random_phase(int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) send_random_run();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    sender_idle_pct = 36;
    recv_idle_pct   = 63;

    // directed: field extremes, slash cases, comment forms, end of text
    send_cp(21'd0, 1'b0);
    send_cp(21'd9, 1'b0);
    send_cp(21'h1FFFFF, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(21'd98, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(21'd32, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(21'd120, 1'b0);
    send_cp(21'd13, 1'b0);
    send_cp(21'd1114111, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(wcs_pkg::CP_STAR, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(wcs_pkg::CP_STAR, 1'b0);
    send_cp(wcs_pkg::CP_STAR, 1'b0);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(21'd100, 1'b1);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(21'd101, 1'b1);
    send_cp(wcs_pkg::CP_SLASH, 1'b0);
    send_cp(wcs_pkg::CP_STAR, 1'b0);
    send_cp(21'd122, 1'b1);
    send_cp(wcs_pkg::CP_SLASH, 1'b1);

    random_phase(45);
    wait_drained();

    sender_idle_pct = 63;
    recv_idle_pct   = 36;
    random_phase(45);
    wait_drained();

    // no idling; first a long result hold while code points keep coming
    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    hold_req = 1'b1;
    repeat (20) send_cp(wcs_pkg::CP_BITS'($urandom_range(65, 90)), 1'b0);
    random_phase(45);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("Covered %0d code points (directed, comment runs, random values), %0d results,",
             items_sent, results_seen);
    $display("under three stall profiles, one long result hold and drained pauses.");
    if (mismatches == 0 && pending == 0) begin
      $display("** whitespace_comment_stripper: PASSED **");
    end else begin
      $display("** whitespace_comment_stripper: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("** whitespace_comment_stripper: FAILED **");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/wcs_pkg.sv
design/wcs_scan.sv
design/wcs_queue.sv
design/whitespace_comment_stripper.sv
test/stripper_checker.sv
test/testbench.sv
